// ===== hdl/gda_pkg.sv =====
// shared types, constants and calendar functions for the date unit
package gda_pkg;

	localparam int YEAR_MAX_DEF   = 9999;
	localparam int DELTA_BITS_DEF = 20;
	localparam int YW             = 14;
	localparam int SW             = 23;
	localparam int DIFF_W         = 23;
	localparam logic [SW-1:0] CYCLE_DAYS = 23'd146097;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_SUB  = 2'd1,
		OP_DIFF = 2'd2,
		OP_CMP  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SER_A,
		ST_SER_B,
		ST_CALC,
		ST_CYCLE,
		ST_YEAR,
		ST_MONTH,
		ST_DONE
	} state_t;

	// datapath commands from the controller
	typedef struct packed {
		logic load;
		logic ser_a;
		logic ser_b;
		logic calc;
		logic cyc_step;
		logic year_step;
		logic month_step;
		logic finish;
	} cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic conv;
		logic cyc_done;
		logic year_done;
		logic month_done;
	} sts_t;

	function automatic logic [8:0] cum_days(input logic [3:0] mi);
		logic [8:0] r;
		unique case (mi)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd59;
			4'd3:    r = 9'd90;
			4'd4:    r = 9'd120;
			4'd5:    r = 9'd151;
			4'd6:    r = 9'd181;
			4'd7:    r = 9'd212;
			4'd8:    r = 9'd243;
			4'd9:    r = 9'd273;
			4'd10:   r = 9'd304;
			default: r = 9'd334;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] mi, input logic lp);
		logic [4:0] r;
		unique case (mi)
			4'd1:                    r = lp ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10: r = 5'd30;
			default:                 r = 5'd31;
		endcase
		return r;
	endfunction

	// divide by 100 through a reciprocal multiply, exact for any 16-bit value
	function automatic logic [15:0] div100(input logic [15:0] x);
		logic [39:0] p;
		p = 40'(x) * 40'd83887;
		return p[38:23];
	endfunction

	function automatic logic leap(input logic [15:0] y);
		logic [15:0] q;
		q = div100(y);
		// century years are leap only when the century count is a multiple of 4
		return (y[1:0] == 2'b00) && (((q * 16'd100) != y) || (q[1:0] == 2'b00));
	endfunction

endpackage

// ===== hdl/gregorian_date_arithmetic_top.sv =====
// sequence: load, serial a, serial b, calc, done; add/subtract also steps c 400-year
// cycles, y remaining years and m months after calc, unless a subtract underflows
// throughput: one request at a time, busy high from accept to result strobe
// result shown one cycle on done; receiver cannot stall
// reset: arst_n asynchronous active low, controller returns to idle
// top level of the date unit
module gregorian_date_arithmetic_top #(
	parameter int YEAR_MAX   = gda_pkg::YEAR_MAX_DEF,
	parameter int DELTA_BITS = gda_pkg::DELTA_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  done,
	input  logic [1:0]            req_type,
	input  logic [4:0]            day_a,
	input  logic [3:0]            month_a,
	input  logic [13:0]           year_a,
	input  logic [4:0]            day_b,
	input  logic [3:0]            month_b,
	input  logic [13:0]           year_b,
	input  logic [DELTA_BITS-1:0] delta_days,
	output logic [4:0]            res_day,
	output logic [3:0]            res_month,
	output logic [13:0]           res_year,
	output logic signed [22:0]    day_diff,
	output logic                  a_before_b,
	output logic                  a_after_b,
	output logic                  dates_equal,
	output logic                  out_of_range
);

	gda_pkg::cmd_t cmd;
	gda_pkg::sts_t sts;

	gda_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
	);

	gda_dp #(.YEAR_MAX(YEAR_MAX), .DELTA_BITS(DELTA_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.req_type(req_type), .day_a(day_a), .month_a(month_a), .year_a(year_a),
		.day_b(day_b), .month_b(month_b), .year_b(year_b), .delta_days(delta_days),
		.done(done), .res_day(res_day), .res_month(res_month), .res_year(res_year),
		.day_diff(day_diff), .a_before_b(a_before_b), .a_after_b(a_after_b),
		.dates_equal(dates_equal), .out_of_range(out_of_range)
	);

`ifndef NO_ASSERTIONS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result beat while busy");
	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot({a_before_b, a_after_b, dates_equal}))
		else $error("compare flags not exclusive");
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_of_range && res_month != 4'd0) |-> 1'b0)
		else $error("date given with range flag");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accept did not raise busy");
`endif

endmodule

// ===== hdl/gda_ctrl.sv =====
// controller state machine for the date unit
module gda_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  gda_pkg::sts_t  sts,
	output gda_pkg::cmd_t  cmd,
	output logic           busy
);

	gda_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= gda_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			gda_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = gda_pkg::ST_SER_A;
				end
			end
			gda_pkg::ST_SER_A: begin
				cmd.ser_a = 1'b1;
				state_d   = gda_pkg::ST_SER_B;
			end
			gda_pkg::ST_SER_B: begin
				cmd.ser_b = 1'b1;
				state_d   = gda_pkg::ST_CALC;
			end
			gda_pkg::ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = sts.conv ? gda_pkg::ST_CYCLE : gda_pkg::ST_DONE;
			end
			gda_pkg::ST_CYCLE: begin
				cmd.cyc_step = 1'b1;
				if (sts.cyc_done) state_d = gda_pkg::ST_YEAR;
			end
			gda_pkg::ST_YEAR: begin
				cmd.year_step = 1'b1;
				if (sts.year_done) state_d = gda_pkg::ST_MONTH;
			end
			gda_pkg::ST_MONTH: begin
				cmd.month_step = 1'b1;
				if (sts.month_done) state_d = gda_pkg::ST_DONE;
			end
			gda_pkg::ST_DONE: begin
				cmd.finish = 1'b1;
				state_d    = gda_pkg::ST_IDLE;
			end
			default: state_d = gda_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== hdl/gda_dp.sv =====
// datapath: day numbers, compare, difference and year/month walk
module gda_dp #(
	parameter int YEAR_MAX   = gda_pkg::YEAR_MAX_DEF,
	parameter int DELTA_BITS = gda_pkg::DELTA_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gda_pkg::cmd_t              cmd,
	output gda_pkg::sts_t              sts,
	input  logic [1:0]                 req_type,
	input  logic [4:0]                 day_a,
	input  logic [3:0]                 month_a,
	input  logic [13:0]                year_a,
	input  logic [4:0]                 day_b,
	input  logic [3:0]                 month_b,
	input  logic [13:0]                year_b,
	input  logic [DELTA_BITS-1:0]      delta_days,
	output logic                       done,
	output logic [4:0]                 res_day,
	output logic [3:0]                 res_month,
	output logic [13:0]                res_year,
	output logic signed [22:0]         day_diff,
	output logic                       a_before_b,
	output logic                       a_after_b,
	output logic                       dates_equal,
	output logic                       out_of_range
);

	localparam int SW = gda_pkg::SW;
	localparam int DW = (DELTA_BITS > SW) ? DELTA_BITS : SW;
	localparam int RW = DW + 1;

	gda_pkg::op_t          op_q;
	logic [4:0]            da_q, db_q;
	logic [3:0]            ma_q, mb_q;
	logic [13:0]           ya_q, yb_q;
	logic [DELTA_BITS-1:0] delta_q;
	logic [SW-1:0]         sa_q, sb_q;
	logic [RW-1:0]         r_q;
	logic [15:0]           yy_q;
	logic [3:0]            mi_q;
	logic                  bad_q;

	// serial of one date, day 1 of january of year 0 is day number 1
	logic [4:0]  ser_d;
	logic [3:0]  ser_m, ser_mm;
	logic [13:0] ser_y;
	logic [SW-1:0] ser_v;
	always_comb begin
		ser_d = cmd.ser_a ? da_q : db_q;
		ser_m = cmd.ser_a ? ma_q : mb_q;
		ser_y = cmd.ser_a ? ya_q : yb_q;
		if (ser_m == 4'd0)      ser_mm = 4'd0;
		else if (ser_m > 4'd12) ser_mm = 4'd11;
		else                    ser_mm = ser_m - 4'd1;
		ser_v = SW'(365 * 32'(ser_y)) + SW'((32'(ser_y) + 32'd3) >> 2)
			- SW'(gda_pkg::div100(16'(ser_y) + 16'd99))
			+ SW'(gda_pkg::div100((16'(ser_y) + 16'd399) >> 2))
			+ SW'(gda_pkg::cum_days(ser_mm))
			+ SW'((ser_mm > 4'd1 && gda_pkg::leap(16'(ser_y))) ? 1 : 0)
			+ SW'(ser_d);
	end

	// serial s = ser_v; walk uses r = s - 1
	logic [RW-1:0] sum_r, sa_ext, dl_ext;
	logic          sub_ok;
	logic signed [SW+1:0] dv;
	always_comb begin
		sa_ext = RW'(sa_q);
		dl_ext = RW'(delta_q);
		sub_ok = dl_ext < sa_ext;
		sum_r  = (op_q == gda_pkg::OP_ADD) ? sa_ext + dl_ext - RW'(1)
			: sa_ext - dl_ext - RW'(1);
		dv = $signed({2'b00, sa_q}) - $signed({2'b00, sb_q});
	end

	logic [8:0] ylen;
	logic [4:0] mlen;
	logic       lp;
	always_comb begin
		lp   = gda_pkg::leap(yy_q);
		ylen = lp ? 9'd366 : 9'd365;
		mlen = gda_pkg::month_len(mi_q, lp);
	end

	assign sts.conv       = (op_q == gda_pkg::OP_ADD) || (op_q == gda_pkg::OP_SUB && sub_ok);
	assign sts.cyc_done   = r_q < RW'(gda_pkg::CYCLE_DAYS);
	assign sts.year_done  = r_q < RW'(ylen);
	assign sts.month_done = (r_q < RW'(mlen)) || (mi_q == 4'd11);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= cmd.finish;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= gda_pkg::op_t'(req_type);
			da_q    <= day_a;   ma_q <= month_a; ya_q <= year_a;
			db_q    <= day_b;   mb_q <= month_b; yb_q <= year_b;
			delta_q <= delta_days;
		end
		if (cmd.ser_a) sa_q <= ser_v;
		if (cmd.ser_b) sb_q <= ser_v;
		if (cmd.calc) begin
			r_q   <= sum_r;
			yy_q  <= '0;
			mi_q  <= '0;
			bad_q <= (op_q == gda_pkg::OP_SUB) && !sub_ok;
		end
		// 400-year cycles stripped one per step
		if (cmd.cyc_step && !sts.cyc_done) begin
			r_q  <= r_q - RW'(gda_pkg::CYCLE_DAYS);
			yy_q <= yy_q + 16'd400;
		end
		if (cmd.year_step && !sts.year_done) begin
			r_q  <= r_q - RW'(ylen);
			yy_q <= yy_q + 16'd1;
		end
		if (cmd.month_step && !sts.month_done) begin
			r_q  <= r_q - RW'(mlen);
			mi_q <= mi_q + 4'd1;
		end
		if (cmd.finish) begin
			a_before_b   <= sa_q < sb_q;
			a_after_b    <= sa_q > sb_q;
			dates_equal  <= sa_q == sb_q;
			if (op_q == gda_pkg::OP_ADD || op_q == gda_pkg::OP_SUB) begin
				day_diff <= '0;
				if (bad_q || yy_q < 16'd1 || 32'(yy_q) > YEAR_MAX) begin
					res_day      <= '0;
					res_month    <= '0;
					res_year     <= '0;
					out_of_range <= 1'b1;
				end else begin
					res_day      <= 5'(r_q) + 5'd1;
					res_month    <= mi_q + 4'd1;
					res_year     <= yy_q[13:0];
					out_of_range <= 1'b0;
				end
			end else begin
				res_day   <= '0;
				res_month <= '0;
				res_year  <= '0;
				if (op_q == gda_pkg::OP_DIFF) begin
					if (dv > $signed((SW+2)'(4194303))) begin
						day_diff <= 23'sd4194303; out_of_range <= 1'b1;
					end else if (dv < -$signed((SW+2)'(4194304))) begin
						day_diff <= -23'sd4194304; out_of_range <= 1'b1;
					end else begin
						day_diff <= dv[22:0]; out_of_range <= 1'b0;
					end
				end else begin
					day_diff     <= '0;
					out_of_range <= 1'b0;
				end
			end
		end
	end

endmodule
